// ===== hdl/afu_pkg.sv =====
// shared constants, payload types and the sigmoid table for the activation unit
package afu_pkg;

  // data format
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // sigmoid value format: Q0.32 plus one integer bit so that 1.0 fits
  localparam int QB = 32;
  localparam int SW = QB + 1;

  // table addressing: steps of 0.5 in the input format
  localparam int STEP_W    = FRAC_BITS - 1;
  localparam int MAG_W     = DATA_WIDTH + 1;
  localparam int KEY_W     = MAG_W - STEP_W;
  localparam int TBL_W     = 16;
  localparam int TBL_STEPS = 16;
  localparam int TBL_IW    = $clog2(TBL_STEPS);
  localparam int TBL_AW    = TBL_IW + 1;
  localparam int PROD_W    = TBL_W + STEP_W;
  localparam int FRAC_SHL  = TBL_W - STEP_W;

  // forward rounding
  localparam int OUT_SH = QB - FRAC_BITS;
  localparam int FWD_W  = FRAC_BITS + 1;

  // derivative product s*(1-s), split into two partial products
  localparam int PP_SPLIT  = 16;
  localparam int PP_HI_W   = 2 * SW - PP_SPLIT;
  localparam int PP_LO_W   = SW + PP_SPLIT;
  localparam int PSUM_W    = 2 * SW;
  localparam int D_SH_SIG  = QB;
  localparam int D_SH_TANH = QB - 2;

  // gradient product
  localparam int BP_W   = DATA_WIDTH + SW;
  localparam int BMAG_W = DATA_WIDTH + 1;

  // divide by ten through a reciprocal, exact for operands below 2^16
  localparam int RECIP_W    = 16;
  localparam int RECIP_SH   = 19;
  localparam int TENTH_BIAS = 5;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(52429);

  // pipeline depth
  localparam int NSTG = 7;

  // configuration port
  localparam int CFG_IW = 4;
  localparam int CFG_DW = 2;
  localparam logic [CFG_IW-1:0] REG_MODE = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_DIR  = CFG_IW'(1);

  // activation modes
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_SIGMOID = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_TANH    = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LRELU   = MODE_W'(2);

  // directions
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] upstream_grad;
    logic                         last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] y_value;
    logic                         last_out;
  } out_item_t;

  // per-transaction control that travels down the pipeline
  typedef struct packed {
    logic [MODE_W-1:0]     cls;
    logic                  dir;
    logic                  gneg;
    logic [DATA_WIDTH-1:0] ga;
    logic                  last;
  } side_t;

  // table lookup result
  typedef struct packed {
    logic [TBL_W-1:0]  base;
    logic [TBL_W:0]    nbase;
    logic [TBL_W-1:0]  diff;
    logic [STEP_W-1:0] step;
    logic              sat;
    logic              sneg;
    side_t             side;
  } lkp_t;

  // sigmoid value and its complement
  typedef struct packed {
    logic [SW-1:0] s;
    logic [SW-1:0] u;
    side_t         side;
  } sval_t;

  // mode and direction of the transaction at the output
  typedef struct packed {
    logic [MODE_W-1:0] cls;
    logic              dir;
  } tag_t;

  // sigmoid at x = 0, 0.5, ..., 8 in unsigned Q0.16
  function automatic logic [TBL_W-1:0] sig_point(input logic [TBL_AW-1:0] idx);
    logic [TBL_W-1:0] val;
    case (idx)
      0:       val = TBL_W'(32768);
      1:       val = TBL_W'(40793);
      2:       val = TBL_W'(47910);
      3:       val = TBL_W'(53580);
      4:       val = TBL_W'(57724);
      5:       val = TBL_W'(60564);
      6:       val = TBL_W'(62428);
      7:       val = TBL_W'(63615);
      8:       val = TBL_W'(64357);
      9:       val = TBL_W'(64816);
      10:      val = TBL_W'(65097);
      11:      val = TBL_W'(65269);
      12:      val = TBL_W'(65374);
      13:      val = TBL_W'(65437);
      14:      val = TBL_W'(65476);
      15:      val = TBL_W'(65500);
      16:      val = TBL_W'(65514);
      default: val = TBL_W'(65514);
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/activation_function_unit.sv =====
// top level of the sigmoid / tanh / leaky relu activation unit
// Streams one transaction per clock unless the output stalls. A result reaches out_valid
// through the seven register stages (table lookup, interpolation multiply, sigmoid and its
// complement, derivative partial products, derivative rounding, gradient multiply, and final
// rounding into the output register). Each stage advances whenever the stage after it is
// empty or moving, so a stalled output only backs up the input once all seven stages hold
// transactions. The mode and direction registers are written through the cfg port, which is
// always ready, and must only change while no transaction is in flight; each transaction picks
// up the settings in force when it is accepted. There is no warm-up after reset.
module activation_function_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  afu_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output afu_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afu_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [afu_pkg::CFG_DW-1:0]     cfg_data
);
  import afu_pkg::*;

  localparam int FWD_ONE = 1 << FRAC_BITS;

  logic [MODE_W-1:0] mode_r;
  logic              dir_r;
  logic [MODE_W-1:0] cls;
  logic [NSTG:1]     en;
  logic [NSTG:1]     vld_nxt;
  logic [NSTG:1]     vld_r;
  lkp_t              lkp;
  sval_t             sval;
  logic [DATA_WIDTH-1:0] lr_y;
  tag_t              out_tag;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LRELU;
      dir_r  <= DIR_FWD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_DIR:  dir_r  <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // unused mode code behaves as leaky relu
  always_comb begin
    unique case (mode_r)
      MODE_SIGMOID: cls = MODE_SIGMOID;
      MODE_TANH:    cls = MODE_TANH;
      default:      cls = MODE_LRELU;
    endcase
  end

  // stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int i = NSTG - 1; i >= 1; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int i = 2; i <= NSTG; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld_r[NSTG];

  // datapath
  afu_lookup u_lookup (
    .clk     (clk),
    .en      (en[1]),
    .in_item (in_data),
    .cls     (cls),
    .dir     (dir_r),
    .lkp     (lkp)
  );

  afu_lrelu u_lrelu (
    .clk     (clk),
    .en      (en[3:1]),
    .in_item (in_data),
    .dir     (dir_r),
    .lr_y    (lr_y)
  );

  afu_interp u_interp (
    .clk  (clk),
    .en   (en[3:2]),
    .lkp  (lkp),
    .sval (sval)
  );

  afu_post u_post (
    .clk      (clk),
    .en       (en[7:4]),
    .sval     (sval),
    .lr_y     (lr_y),
    .out_item (out_data),
    .out_tag  (out_tag)
  );

  // input only backs up when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled with a free pipeline stage");

  // a moving transaction in the last internal stage reaches the output register
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-1] && en[NSTG]) |=> vld_r[NSTG])
    else $error("transaction lost before the output register");

  // forward sigmoid stays within [0, 1]
  a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tag.cls == MODE_SIGMOID && out_tag.dir == DIR_FWD) |->
    (out_data.y_value >= 0 && out_data.y_value <= FWD_ONE))
    else $error("forward sigmoid out of range");

  // forward tanh stays within [-1, 1]
  a_tanh_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tag.cls == MODE_TANH && out_tag.dir == DIR_FWD) |->
    (out_data.y_value >= -FWD_ONE && out_data.y_value <= FWD_ONE))
    else $error("forward tanh out of range");

endmodule

// ===== hdl/afu_lookup.sv =====
// stage 1: input magnitudes, table segment lookup and gradient sign split
module afu_lookup (
  input  logic                      clk,
  input  logic                      en,
  input  afu_pkg::in_item_t         in_item,
  input  logic [afu_pkg::MODE_W-1:0] cls,
  input  logic                      dir,
  output afu_pkg::lkp_t             lkp
);
  import afu_pkg::*;

  logic                  xneg;
  logic                  gneg;
  logic [MAG_W-1:0]      xe;
  logic [MAG_W-1:0]      xa;
  logic [MAG_W-1:0]      mag;
  logic [KEY_W-1:0]      key;
  logic [TBL_AW-1:0]     idx;
  logic [TBL_W-1:0]      base;
  logic [TBL_W-1:0]      nxtp;
  logic [DATA_WIDTH-1:0] graw;
  lkp_t                  lkp_nxt;
  lkp_t                  lkp_r;

  // |x|, doubled for tanh
  always_comb begin
    xneg = in_item.x_value[DATA_WIDTH-1];
    xe   = {in_item.x_value[DATA_WIDTH-1], in_item.x_value};
    xa   = xneg ? (~xe + 1'b1) : xe;
    mag  = (cls == MODE_TANH) ? {xa[MAG_W-2:0], 1'b0} : xa;
  end

  // segment index and the two table points around it
  always_comb begin
    key  = mag[MAG_W-1:STEP_W];
    idx  = {1'b0, key[TBL_IW-1:0]};
    base = sig_point(idx);
    nxtp = sig_point(TBL_AW'(idx + 1'b1));
  end

  // assemble the stage register contents
  always_comb begin
    graw               = in_item.upstream_grad;
    gneg               = graw[DATA_WIDTH-1];
    lkp_nxt.base       = base;
    lkp_nxt.nbase      = {1'b1, {TBL_W{1'b0}}} - {1'b0, base};
    lkp_nxt.diff       = nxtp - base;
    lkp_nxt.step       = mag[STEP_W-1:0];
    lkp_nxt.sat        = key >= KEY_W'(TBL_STEPS);
    lkp_nxt.sneg       = xneg;
    lkp_nxt.side.cls   = cls;
    lkp_nxt.side.dir   = dir;
    lkp_nxt.side.gneg  = gneg;
    lkp_nxt.side.ga    = gneg ? (~graw + 1'b1) : graw;
    lkp_nxt.side.last  = in_item.last_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lkp_r <= lkp_nxt;
    end
  end

  assign lkp = lkp_r;

endmodule

// ===== hdl/afu_lrelu.sv =====
// stages 1 to 3: leaky relu value or gradient, negative side scaled by one tenth
module afu_lrelu (
  input  logic                             clk,
  input  logic [2:0]                       en,
  input  afu_pkg::in_item_t                in_item,
  input  logic                             dir,
  output logic [afu_pkg::DATA_WIDTH-1:0]   lr_y
);
  import afu_pkg::*;

  logic [DATA_WIDTH-1:0]         v;
  logic                          vneg;
  logic [DATA_WIDTH-1:0]         vmag;
  logic [DATA_WIDTH-1:0]         qt;
  logic [DATA_WIDTH-1:0]         y_nxt;
  logic [DATA_WIDTH+RECIP_W-1:0] q_nxt;

  logic [DATA_WIDTH-1:0]         pass1_r;
  logic [DATA_WIDTH-1:0]         n1_r;
  logic                          xneg1_r;
  logic                          vneg1_r;
  logic [DATA_WIDTH+RECIP_W-1:0] q2_r;
  logic [DATA_WIDTH-1:0]         pass2_r;
  logic                          xneg2_r;
  logic                          vneg2_r;
  logic [DATA_WIDTH-1:0]         y3_r;

  // pick x or the gradient, and form |v| plus the rounding bias
  always_comb begin
    v    = (dir == DIR_BWD) ? in_item.upstream_grad : in_item.x_value;
    vneg = v[DATA_WIDTH-1];
    vmag = vneg ? (~v + 1'b1) : v;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pass1_r <= v;
      n1_r    <= vmag + DATA_WIDTH'(TENTH_BIAS);
      xneg1_r <= in_item.x_value[DATA_WIDTH-1];
      vneg1_r <= vneg;
    end
  end

  // multiply by the reciprocal of ten
  assign q_nxt = (DATA_WIDTH+RECIP_W)'(n1_r) * (DATA_WIDTH+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q2_r    <= q_nxt;
      pass2_r <= pass1_r;
      xneg2_r <= xneg1_r;
      vneg2_r <= vneg1_r;
    end
  end

  // quotient, sign restore, and the positive-side pass-through
  always_comb begin
    qt = DATA_WIDTH'(q2_r >> RECIP_SH);
    if (xneg2_r) begin
      y_nxt = vneg2_r ? (~qt + 1'b1) : qt;
    end else begin
      y_nxt = pass2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y3_r <= y_nxt;
    end
  end

  assign lr_y = y3_r;

endmodule

// ===== hdl/afu_interp.sv =====
// stages 2 and 3: linear interpolation between table points, sigmoid and 1 - sigmoid
module afu_interp (
  input  logic             clk,
  input  logic [1:0]       en,
  input  afu_pkg::lkp_t    lkp,
  output afu_pkg::sval_t   sval
);
  import afu_pkg::*;

  localparam logic [SW-1:0] ONE_S = {1'b1, {QB{1'b0}}};

  logic [PROD_W-1:0] prod_nxt;
  logic [SW-1:0]     frac;
  logic [SW-1:0]     spos;
  logic [SW-1:0]     comp;
  sval_t             sval_nxt;

  logic [PROD_W-1:0] prod2_r;
  logic [TBL_W-1:0]  base2_r;
  logic [TBL_W:0]    nbase2_r;
  logic              sat2_r;
  logic              sneg2_r;
  side_t             side2_r;
  sval_t             sval_r;

  // slope times position inside the segment
  assign prod_nxt = PROD_W'(lkp.diff) * PROD_W'(lkp.step);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod2_r  <= prod_nxt;
      base2_r  <= lkp.base;
      nbase2_r <= lkp.nbase;
      sat2_r   <= lkp.sat;
      sneg2_r  <= lkp.sneg;
      side2_r  <= lkp.side;
    end
  end

  // sigmoid of |x| and its complement side by side, then mirror for negative x
  always_comb begin
    frac = SW'(prod2_r) << FRAC_SHL;
    spos = (SW'(base2_r) << TBL_W) + frac;
    comp = (SW'(nbase2_r) << TBL_W) - frac;
    if (sat2_r) begin
      spos = ONE_S;
      comp = '0;
    end
    sval_nxt.s    = sneg2_r ? comp : spos;
    sval_nxt.u    = sneg2_r ? spos : comp;
    sval_nxt.side = side2_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sval_r <= sval_nxt;
    end
  end

  assign sval = sval_r;

endmodule

// ===== hdl/afu_post.sv =====
// stages 4 to 7: forward rounding, derivative products, gradient scaling and result select
module afu_post (
  input  logic                           clk,
  input  logic [3:0]                     en,
  input  afu_pkg::sval_t                 sval,
  input  logic [afu_pkg::DATA_WIDTH-1:0] lr_y,
  output afu_pkg::out_item_t             out_item,
  output afu_pkg::tag_t                  out_tag
);
  import afu_pkg::*;

  localparam logic [SW:0]         FWD_HALF = (SW + 1)'(1) << (OUT_SH - 1);
  localparam logic [PSUM_W-1:0]   RND_SIG  = PSUM_W'(1) << (D_SH_SIG - 1);
  localparam logic [PSUM_W-1:0]   RND_TANH = PSUM_W'(1) << (D_SH_TANH - 1);
  localparam logic [BP_W:0]       BWD_HALF = (BP_W + 1)'(1) << (QB - 1);
  localparam logic [DATA_WIDTH-1:0] SAT_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // stage 4 logic
  logic              is_tanh4;
  logic [SW:0]       sig_sum;
  logic              s_ge_u;
  logic [SW:0]       tpos;
  logic [SW:0]       tneg;
  logic [SW:0]       tsel;
  logic [FWD_W-1:0]  fmag_nxt;
  logic [PP_HI_W-1:0] pph_nxt;
  logic [PP_LO_W-1:0] ppl_nxt;

  // stage 5 logic
  logic              is_tanh5;
  logic [PSUM_W-1:0] psum;
  logic [SW-1:0]     d_nxt;

  // stage 6 logic
  logic [BP_W-1:0]   bp_nxt;

  // stage 7 logic
  logic [BP_W:0]         bsum;
  logic [BMAG_W-1:0]     bmag;
  logic [DATA_WIDTH-1:0] fext;
  logic [DATA_WIDTH-1:0] fwd_y;
  logic [DATA_WIDTH-1:0] bwd_y;
  out_item_t             item_nxt;
  tag_t                  tag_nxt;

  // stage registers
  logic [PP_HI_W-1:0]    pph4_r;
  logic [PP_LO_W-1:0]    ppl4_r;
  logic [FWD_W-1:0]      fmag4_r;
  logic                  fneg4_r;
  logic [DATA_WIDTH-1:0] lr4_r;
  side_t                 side4_r;
  logic [SW-1:0]         d5_r;
  logic [FWD_W-1:0]      fmag5_r;
  logic                  fneg5_r;
  logic [DATA_WIDTH-1:0] lr5_r;
  side_t                 side5_r;
  logic [BP_W-1:0]       bp6_r;
  logic [FWD_W-1:0]      fmag6_r;
  logic                  fneg6_r;
  logic [DATA_WIDTH-1:0] lr6_r;
  side_t                 side6_r;
  out_item_t             item7_r;
  tag_t                  tag7_r;

  // forward result magnitude: round s, or |2s - 1| for tanh
  always_comb begin
    is_tanh4 = sval.side.cls == MODE_TANH;
    sig_sum  = {1'b0, sval.s} + FWD_HALF;
    s_ge_u   = sval.s >= sval.u;
    tpos     = {1'b0, sval.s} - {1'b0, sval.u} + FWD_HALF;
    tneg     = {1'b0, sval.u} - {1'b0, sval.s} + FWD_HALF;
    tsel     = s_ge_u ? tpos : tneg;
    fmag_nxt = is_tanh4 ? tsel[OUT_SH +: FWD_W] : sig_sum[OUT_SH +: FWD_W];
  end

  // partial products of s * (1 - s)
  assign pph_nxt = PP_HI_W'(sval.s) * PP_HI_W'(sval.u[SW-1:PP_SPLIT]);
  assign ppl_nxt = PP_LO_W'(sval.s) * PP_LO_W'(sval.u[PP_SPLIT-1:0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pph4_r  <= pph_nxt;
      ppl4_r  <= ppl_nxt;
      fmag4_r <= fmag_nxt;
      fneg4_r <= is_tanh4 && !s_ge_u;
      lr4_r   <= lr_y;
      side4_r <= sval.side;
    end
  end

  // combine partial products and round to the derivative
  always_comb begin
    is_tanh5 = side4_r.cls == MODE_TANH;
    psum     = (PSUM_W'(pph4_r) << PP_SPLIT) + PSUM_W'(ppl4_r)
               + (is_tanh5 ? RND_TANH : RND_SIG);
    d_nxt    = is_tanh5 ? psum[D_SH_TANH +: SW] : psum[D_SH_SIG +: SW];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d5_r    <= d_nxt;
      fmag5_r <= fmag4_r;
      fneg5_r <= fneg4_r;
      lr5_r   <= lr4_r;
      side5_r <= side4_r;
    end
  end

  // upstream gradient magnitude times derivative
  assign bp_nxt = BP_W'(side5_r.ga) * BP_W'(d5_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      bp6_r   <= bp_nxt;
      fmag6_r <= fmag5_r;
      fneg6_r <= fneg5_r;
      lr6_r   <= lr5_r;
      side6_r <= side5_r;
    end
  end

  // round, restore sign, saturate, and select the result
  always_comb begin
    bsum  = {1'b0, bp6_r} + BWD_HALF;
    bmag  = bsum[QB +: BMAG_W];
    fext  = DATA_WIDTH'(fmag6_r);
    fwd_y = fneg6_r ? (~fext + 1'b1) : fext;
    if (side6_r.gneg) begin
      bwd_y = (bmag > {1'b0, SAT_NEG}) ? SAT_NEG : (~bmag[DATA_WIDTH-1:0] + 1'b1);
    end else begin
      bwd_y = (bmag > {1'b0, SAT_POS}) ? SAT_POS : bmag[DATA_WIDTH-1:0];
    end
    if (side6_r.cls == MODE_LRELU) begin
      item_nxt.y_value = lr6_r;
    end else if (side6_r.dir == DIR_FWD) begin
      item_nxt.y_value = fwd_y;
    end else begin
      item_nxt.y_value = bwd_y;
    end
    item_nxt.last_out = side6_r.last;
    tag_nxt.cls       = side6_r.cls;
    tag_nxt.dir       = side6_r.dir;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      item7_r <= item_nxt;
      tag7_r  <= tag_nxt;
    end
  end

  assign out_item = item7_r;
  assign out_tag  = tag7_r;

endmodule
